// ===== rtl/core/fca_pkg.sv =====
package fca_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int ENTRY_W         = 32;
  localparam int POS_W           = 11;
  localparam int CNT_W           = 11;
  localparam int BLK_W           = 10;
  localparam int RSV_W           = 10;
  localparam int REQ_W           = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int IN_DATA_W       = 24;
  localparam int OUT_DATA_W      = 24;

  // Reset values of the registers and of the next-free pointer.
  localparam logic [POS_W-1:0] TOTAL_RST     = 11'd1024;
  localparam logic [RSV_W-1:0] RESERVED_RST  = 10'd10;
  localparam logic [POS_W-1:0] NEXT_FREE_RST = 11'd10;

  // Special table entry values.
  localparam logic [ENTRY_W-1:0] ENTRY_FREE     = 32'h0000_0000;
  localparam logic [ENTRY_W-1:0] ENTRY_END      = 32'hFFFF_FFFF;
  localparam logic [ENTRY_W-1:0] ENTRY_RESERVED = 32'hFFFF_FFFE;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_FORMAT  = 2'd0,
    REQ_ALLOC   = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_BAD_CHAIN  = 2'd2,
    ST_ZERO_COUNT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FORMAT,
    S_ALLOC_CHK,
    S_ALLOC_LINK,
    S_ALLOC_SRCH,
    S_REL_CHK,
    S_REL_WALK,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic [POS_W-1:0] total;
    logic [RSV_W-1:0] reserved;
  } cfg_t;

  typedef struct packed {
    req_t             req;
    logic [CNT_W-1:0] count;
    logic [BLK_W-1:0] start;
  } request_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] first_block;
    logic [POS_W-1:0] next_free;
  } result_t;

endpackage

// ===== rtl/core/fca_ram.sv =====
module fca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data (old data on collision).
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/fca_seq.sv =====
module fca_seq #(
  parameter int TABLE_DEPTH = fca_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  fca_pkg::request_t              req,
  input  fca_pkg::cfg_t                  cfg,
  output logic                           res_valid,
  input  logic                           res_ready,
  output fca_pkg::result_t               res,
  output logic                           wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  output logic [fca_pkg::ENTRY_W-1:0]    wr_data,
  output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  input  logic [fca_pkg::ENTRY_W-1:0]    rd_data
);
  import fca_pkg::*;

  localparam int AW        = $clog2(TABLE_DEPTH);
  localparam int TOTAL_MAX = (1 << POS_W) - 1;
  localparam logic [POS_W-1:0] DEPTH_CAP =
    (TABLE_DEPTH > TOTAL_MAX) ? POS_W'(TOTAL_MAX) : POS_W'(TABLE_DEPTH);

  seq_state_t       state_r, state_nxt;
  request_t         req_r, req_nxt;
  result_t          res_r, res_nxt;
  logic [POS_W-1:0] cur_r, cur_nxt;
  logic [POS_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;
  logic [POS_W-1:0] steps_r, steps_nxt;
  logic [POS_W-1:0] nf_r, nf_nxt;
  logic             pend_end_r, pend_end_nxt;
  logic             byp_r, byp_nxt;
  logic [POS_W-1:0] wr_pos;

  // Shared compare and increment terms used by every request walk.
  logic [POS_W-1:0]   t_eff;
  logic [ENTRY_W-1:0] d;
  logic               cur_ge_t;
  logic [POS_W-1:0]   cur_inc;
  logic               space_bad;
  logic               d_ge_t;
  logic               steps_lim;
  logic               link_last;
  logic               d_free;

  assign t_eff     = (cfg.total < DEPTH_CAP) ? cfg.total : DEPTH_CAP;
  // A release that just freed the entry it reads next sees the fresh zero.
  assign d         = byp_r ? ENTRY_FREE : rd_data;
  assign d_free    = (d == ENTRY_FREE);
  assign cur_ge_t  = (cur_r >= t_eff);
  assign cur_inc   = cur_r + POS_W'(1);
  assign space_bad = ({1'b0, nf_r} + {1'b0, req_r.count}) > {1'b0, t_eff};
  assign d_ge_t    = (d >= ENTRY_W'(t_eff));
  assign steps_lim = ((steps_r + POS_W'(1)) >= t_eff);
  assign link_last = ((done_r + CNT_W'(1)) == (req_r.count - CNT_W'(1)));

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res       = res_r;
  assign rd_addr   = AW'(cur_nxt);
  assign wr_addr   = AW'(wr_pos);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.req)
            REQ_FORMAT:  state_nxt = S_FORMAT;
            REQ_ALLOC:   state_nxt = S_ALLOC_CHK;
            REQ_RELEASE: state_nxt = S_REL_CHK;
            REQ_NONE:    state_nxt = S_FIN;
          endcase
        end
      end
      S_FORMAT: begin
        if (cur_ge_t) state_nxt = S_FIN;
      end
      S_ALLOC_CHK: begin
        priority if (req_r.count == '0 || space_bad) state_nxt = S_FIN;
        else if (req_r.count == CNT_W'(1))           state_nxt = S_ALLOC_SRCH;
        else                                          state_nxt = S_ALLOC_LINK;
      end
      S_ALLOC_LINK: begin
        priority if (cur_ge_t)             state_nxt = S_FIN;
        else if (d_free && link_last)      state_nxt = S_ALLOC_SRCH;
        else                               state_nxt = S_ALLOC_LINK;
      end
      S_ALLOC_SRCH: begin
        if (cur_ge_t || d_free) state_nxt = S_FIN;
      end
      S_REL_CHK: begin
        state_nxt = cur_ge_t ? S_FIN : S_REL_WALK;
      end
      S_REL_WALK: begin
        if (d == ENTRY_RESERVED || d == ENTRY_END || d_ge_t || steps_lim) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates and table accesses.
  always_comb begin
    req_nxt      = req_r;
    res_nxt      = res_r;
    cur_nxt      = cur_r;
    last_nxt     = last_r;
    done_nxt     = done_r;
    steps_nxt    = steps_r;
    nf_nxt       = nf_r;
    pend_end_nxt = pend_end_r;
    byp_nxt      = 1'b0;
    wr_en        = 1'b0;
    wr_pos       = cur_r;
    wr_data      = ENTRY_FREE;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt      = req;
          res_nxt      = '{status: ST_OK, first_block: '0, next_free: nf_r};
          done_nxt     = '0;
          steps_nxt    = '0;
          pend_end_nxt = 1'b0;
          cur_nxt      = '0;
          if (req.req == REQ_RELEASE) begin
            cur_nxt           = {1'b0, req.start};
            nf_nxt            = {1'b0, req.start};
            res_nxt.next_free = {1'b0, req.start};
          end
        end
      end
      S_FORMAT: begin
        if (cur_ge_t) begin
          nf_nxt            = {1'b0, cfg.reserved};
          res_nxt.next_free = {1'b0, cfg.reserved};
        end else begin
          wr_en   = 1'b1;
          wr_pos  = cur_r;
          wr_data = (cur_r < {1'b0, cfg.reserved}) ? ENTRY_RESERVED : ENTRY_FREE;
          cur_nxt = cur_inc;
        end
      end
      S_ALLOC_CHK: begin
        priority if (req_r.count == '0) begin
          res_nxt.status = ST_ZERO_COUNT;
        end else if (space_bad) begin
          res_nxt.status = ST_NO_SPACE;
        end else begin
          last_nxt     = nf_r;
          cur_nxt      = nf_r + POS_W'(1);
          pend_end_nxt = (req_r.count == CNT_W'(1));
        end
      end
      S_ALLOC_LINK: begin
        if (cur_ge_t) begin
          res_nxt.status = ST_NO_SPACE;
        end else begin
          if (d_free) begin
            wr_en    = 1'b1;
            wr_pos   = last_r;
            wr_data  = ENTRY_W'(cur_r);
            last_nxt = cur_r;
            done_nxt = done_r + CNT_W'(1);
            if (link_last) pend_end_nxt = 1'b1;
          end
          cur_nxt = cur_inc;
        end
      end
      S_ALLOC_SRCH: begin
        // Close the chain while the forward search runs.
        if (pend_end_r) begin
          wr_en        = 1'b1;
          wr_pos       = last_r;
          wr_data      = ENTRY_END;
          pend_end_nxt = 1'b0;
        end
        if (cur_ge_t || d_free) begin
          nf_nxt  = cur_ge_t ? t_eff : cur_r;
          res_nxt = '{status: ST_OK, first_block: nf_r[BLK_W-1:0],
                      next_free: (cur_ge_t ? t_eff : cur_r)};
        end else begin
          cur_nxt = cur_inc;
        end
      end
      S_REL_CHK: begin
        if (cur_ge_t) res_nxt.status = ST_BAD_CHAIN;
      end
      S_REL_WALK: begin
        if (d == ENTRY_RESERVED) begin
          res_nxt.status = ST_BAD_CHAIN;
        end else begin
          wr_en   = 1'b1;
          wr_pos  = cur_r;
          wr_data = ENTRY_FREE;
          priority if (d == ENTRY_END) begin
            res_nxt.status = ST_OK;
          end else if (d_ge_t || steps_lim) begin
            res_nxt.status = ST_BAD_CHAIN;
          end else begin
            cur_nxt   = d[POS_W-1:0];
            steps_nxt = steps_r + POS_W'(1);
            byp_nxt   = (d[POS_W-1:0] == cur_r);
          end
        end
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Control state is reset; the walk registers are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      nf_r       <= NEXT_FREE_RST;
      pend_end_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      nf_r       <= nf_nxt;
      pend_end_r <= pend_end_nxt;
      byp_r      <= byp_nxt;
    end
    req_r   <= req_nxt;
    res_r   <= res_nxt;
    cur_r   <= cur_nxt;
    last_r  <= last_nxt;
    done_r  <= done_nxt;
    steps_r <= steps_nxt;
  end

endmodule

// ===== rtl/core/fat_chain_allocator.sv =====
// Format writes the table up to T, allocate searches up to T, and release follows the chain one
// entry at a time, where T is min(total_blocks, TABLE_DEPTH); the request idles the block meanwhile.
// Throughput is one request per walk: the walk reads one table entry per cycle through
// the single read port of the table memory, and the result leaves through an output register.
// Reset (rst_n low, synchronous) restores the registers and next_free to their defaults;
// the table itself is undefined until a format request has written it.
module fat_chain_allocator #(
  parameter int TABLE_DEPTH = fca_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata fields from bit 0: block_total_req[10:0], start_block[20:11], zero fill.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fca_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser fields from bit 0: req_type[1:0].
  input  logic [fca_pkg::REQ_W-1:0]         in_tuser,
  // out_tdata fields from bit 0: status[1:0], first_block[11:2], next_free_out[22:12],
  // zero fill.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fca_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fca_pkg::POS_W-1:0]         cfg_data
);
  import fca_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [POS_W-1:0]   total_r;
  logic [RSV_W-1:0]   reserved_r;
  cfg_t               cfg;
  request_t           req;
  result_t            res;
  logic               res_valid;
  logic               res_ready;
  result_t            out_data_r;
  logic               out_valid_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // Configuration registers take a beat in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= TOTAL_RST;
      reserved_r <= RESERVED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOTAL:    total_r    <= cfg_data;
        CFG_RESERVED: reserved_r <= cfg_data[RSV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{total: total_r, reserved: reserved_r};

  // Unpack the input beat.
  assign req = '{req:   req_t'(in_tuser),
                 count: in_tdata[CNT_W-1:0],
                 start: in_tdata[CNT_W +: BLK_W]};

  fca_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req      (req),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  fca_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Output register: holds a finished result until the downstream beat completes.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r.next_free, out_data_r.first_block,
                       out_data_r.status};

endmodule
